// ----- rtl/ips_pkg.sv -----
// ----------------------------------------------------------------------------
// ips_pkg
// Shared types for the interval priority sweep: transaction payloads,
// controller state codes and the controller-to-datapath command group.
// ----------------------------------------------------------------------------
package ips_pkg;

  localparam int TIME_W = 64;
  localparam int TYPE_W = 4;
  // Highest number of types a 4-bit type field can reach
  localparam int TYPE_CODES = 1 << TYPE_W;

  typedef struct packed {
    logic [TIME_W-1:0] boundary_time;
    logic [TYPE_W-1:0] boundary_type;
    logic              start_flag;
    logic              last_boundary;
  } in_item_t;

  typedef struct packed {
    logic [TYPE_W-1:0] segment_type;
    logic [TIME_W-1:0] segment_begin;
    logic [TIME_W-1:0] segment_end;
    logic              last_segment;
  } out_item_t;

  // EMPTY: no boundary of the current set seen yet; OPEN: previous time held
  typedef enum logic [1:0] {
    ST_EMPTY = 2'b01,
    ST_OPEN  = 2'b10
  } ctrl_state_t;

  typedef struct packed {
    logic apply;     // apply start/end to counts, keep boundary time
    logic clear;     // drop all counts at the end of a set
    logic load_out;  // capture a segment into the output register
  } dp_cmd_t;

endpackage

// ----- rtl/ips_ctrl.sv -----
// ----------------------------------------------------------------------------
// ips_ctrl
// Controller: tracks whether a set is open, owns the output valid flag and
// the input stall, and issues commands to the datapath.
// ----------------------------------------------------------------------------
module ips_ctrl (
  input  logic            clk,
  input  logic            rst_n,
  input  logic            in_valid,
  input  logic            in_last,
  output logic            in_stall,
  output logic            out_valid,
  input  logic            out_stall,
  output ips_pkg::dp_cmd_t cmd
);

  ips_pkg::ctrl_state_t state_r, state_nxt;
  logic                 out_valid_r, out_valid_nxt;
  logic                 accept;
  logic                 emit;

  // Hold the input only while a finished segment is still waiting
  assign in_stall  = out_valid_r & out_stall;
  assign accept    = in_valid & ~in_stall;
  assign emit      = accept & (state_r == ips_pkg::ST_OPEN);
  assign out_valid = out_valid_r;

  assign cmd.apply    = accept & ~in_last;
  assign cmd.clear    = accept & in_last;
  assign cmd.load_out = emit;

  always_comb begin
    state_nxt = state_r;
    case (state_r)
      ips_pkg::ST_EMPTY: begin
        if (accept && !in_last) begin
          state_nxt = ips_pkg::ST_OPEN;
        end
      end
      ips_pkg::ST_OPEN: begin
        if (accept && in_last) begin
          state_nxt = ips_pkg::ST_EMPTY;
        end
      end
      default: state_nxt = ips_pkg::ST_EMPTY;
    endcase
  end

  always_comb begin
    if (emit) begin
      out_valid_nxt = 1'b1;
    end else if (out_stall) begin
      out_valid_nxt = out_valid_r;
    end else begin
      out_valid_nxt = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ips_pkg::ST_EMPTY;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

endmodule

// ----- rtl/ips_datapath.sv -----
// ----------------------------------------------------------------------------
// ips_datapath
// Datapath: per-type open counters with nonzero flags, a priority encoder
// over the flags, the previous boundary time and the output register.
// ----------------------------------------------------------------------------
module ips_datapath #(
  parameter int NUM_TYPES   = 14,
  parameter int COUNT_WIDTH = 16
) (
  input  logic               clk,
  input  logic               rst_n,
  input  ips_pkg::in_item_t  in_data,
  input  ips_pkg::dp_cmd_t   cmd,
  output ips_pkg::out_item_t out_data
);

  // Types above the 4-bit field range can never be touched
  localparam int NUM_LIVE = (NUM_TYPES < ips_pkg::TYPE_CODES) ? NUM_TYPES
                                                              : ips_pkg::TYPE_CODES;
  localparam int IDX_W = $clog2(NUM_LIVE);
  localparam logic [ips_pkg::TYPE_W:0] LIVE_LIM = (ips_pkg::TYPE_W + 1)'(NUM_LIVE);

  logic [COUNT_WIDTH-1:0]       count_r   [NUM_LIVE];
  logic [COUNT_WIDTH-1:0]       count_nxt [NUM_LIVE];
  logic [NUM_LIVE-1:0]          nz_r, nz_nxt;
  logic [ips_pkg::TIME_W-1:0]   prev_time_r;
  logic [ips_pkg::TYPE_W-1:0]   prio;
  logic                         in_range;
  logic [IDX_W-1:0]             idx;
  ips_pkg::out_item_t           out_r;

  assign in_range = {1'b0, in_data.boundary_type} < LIVE_LIM;
  assign idx      = in_data.boundary_type[IDX_W-1:0];

  always_comb begin
    for (int i = 0; i < NUM_LIVE; i++) begin
      count_nxt[i] = count_r[i];
      if (cmd.clear) begin
        count_nxt[i] = '0;
      end else if (cmd.apply && in_range && (idx == IDX_W'(i))) begin
        if (in_data.start_flag) begin
          // saturate at all ones
          if (!(&count_r[i])) begin
            count_nxt[i] = count_r[i] + COUNT_WIDTH'(1);
          end
        end else if (nz_r[i]) begin
          count_nxt[i] = count_r[i] - COUNT_WIDTH'(1);
        end
      end
      nz_nxt[i] = |count_nxt[i];
    end
  end

  // Highest type with a positive count, 0 when none
  always_comb begin
    prio = '0;
    for (int i = 0; i < NUM_LIVE; i++) begin
      if (nz_r[i]) begin
        prio = ips_pkg::TYPE_W'(i);
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      for (int i = 0; i < NUM_LIVE; i++) begin
        count_r[i] <= '0;
      end
      nz_r <= '0;
    end else begin
      count_r <= count_nxt;
      nz_r    <= nz_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.apply) begin
      prev_time_r <= in_data.boundary_time;
    end
    if (cmd.load_out) begin
      out_r.segment_type  <= prio;
      out_r.segment_begin <= prev_time_r;
      // clamp a backward time step to an empty segment
      out_r.segment_end   <= (in_data.boundary_time < prev_time_r) ? prev_time_r
                                                                   : in_data.boundary_time;
      out_r.last_segment  <= in_data.last_boundary;
    end
  end

  assign out_data = out_r;

endmodule

// ----- rtl/interval_priority_sweep.sv -----
// ----------------------------------------------------------------------------
// interval_priority_sweep
// Sweep over time-sorted interval boundaries; emits labelled segments.
// ----------------------------------------------------------------------------
// Usage:
//   in_*  : one boundary per transaction (time, type, start/end, last flag).
//   out_* : one segment per boundary after the first of a set, labelled with
//           the highest type open after the previous boundary (0 if none).
//   A transaction moves on a rising edge with valid high and stall low.
// Latency: the segment a boundary causes is registered and appears in the output
//   register in the cycle after that boundary is taken.
// Throughput: one boundary per cycle while in_stall is low; the open counters are
//   updated for each accepted boundary and the priority encoder reads the registered nonzero flags.
// A boundary flagged last emits its segment (if its set is open) and clears all counts; the next
//   boundary starts a new set and emits nothing.
// Reset (rst_n low, synchronous) clears the counters, the set state and the
//   output valid flag.
// When out_stall holds a pending segment, in_stall rises and the segment
//   stays put until it is taken; with the output register empty the input
//   is never stalled.
// ----------------------------------------------------------------------------
module interval_priority_sweep #(
  parameter int NUM_TYPES   = 14,
  parameter int COUNT_WIDTH = 16
) (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               in_valid,
  output logic               in_stall,
  input  ips_pkg::in_item_t  in_data,
  output logic               out_valid,
  input  logic               out_stall,
  output ips_pkg::out_item_t out_data
);

  ips_pkg::dp_cmd_t cmd;

  ips_ctrl u_ctrl (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_last   (in_data.last_boundary),
    .in_stall  (in_stall),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .cmd       (cmd)
  );

  ips_datapath #(
    .NUM_TYPES   (NUM_TYPES),
    .COUNT_WIDTH (COUNT_WIDTH)
  ) u_datapath (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_data  (in_data),
    .cmd      (cmd),
    .out_data (out_data)
  );

endmodule

// ----- rtl/ips_checker.sv -----
// ----------------------------------------------------------------------------
// ips_checker
// Port-level checks for the interval priority sweep, bound to the top level.
// ----------------------------------------------------------------------------
module ips_checker #(
  parameter int NUM_TYPES = 14
) (
  input logic               clk,
  input logic               rst_n,
  input logic               in_valid,
  input logic               in_stall,
  input logic               out_valid,
  input logic               out_stall,
  input ips_pkg::out_item_t out_data
);

  // A stalled segment holds until taken
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_stall |=> out_valid && $stable(out_data))
    else $error("stalled segment changed or dropped");

  // Input is stalled only behind a pending, stalled segment
  a_stall_cause: assert property (@(posedge clk) disable iff (!rst_n)
    in_stall |-> out_valid && out_stall)
    else $error("input stalled without a pending segment");

  // A new segment follows an accepted boundary
  a_seg_cause: assert property (@(posedge clk) disable iff (!rst_n)
    $rose(out_valid) |-> $past(in_valid && !in_stall))
    else $error("segment appeared without an accepted boundary");

  // Segments never run backward
  a_seg_order: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> out_data.segment_end >= out_data.segment_begin)
    else $error("segment end below segment begin");

  // Label is always a tracked type
  a_seg_type: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> 32'(out_data.segment_type) < NUM_TYPES)
    else $error("segment type out of range");

endmodule

bind interval_priority_sweep ips_checker #(
  .NUM_TYPES (NUM_TYPES)
) u_ips_checker (
  .clk       (clk),
  .rst_n     (rst_n),
  .in_valid  (in_valid),
  .in_stall  (in_stall),
  .out_valid (out_valid),
  .out_stall (out_stall),
  .out_data  (out_data)
);
